/* sv/gclv_pkg.sv */
// Shared types, codes and mask bits for the G-code line word validator.
// No dependencies; imported by every module of the block.
package gclv_pkg;

  localparam int AXES = 3;
  localparam int COORD_SYSTEMS_DEF = 6;
  localparam int MAX_TOOL_DEF = 127;
  localparam int MAX_LINE_DEF = 127;
  localparam int MASK_W = 27;
  localparam int SLOTS = 9;

  // seen-word mask bits
  localparam int B_X = 0;
  localparam int B_Y = 1;
  localparam int B_Z = 2;
  localparam int B_I = 3;
  localparam int B_J = 4;
  localparam int B_K = 5;
  localparam int B_R = 6;
  localparam int B_F = 7;
  localparam int B_P = 8;
  localparam int B_S = 9;
  localparam int B_L = 10;
  localparam int B_T = 11;
  localparam int B_N = 12;
  localparam int GR_NONMODAL = 13;
  localparam int GR_MOTION = 14;
  localparam int GR_PLANE = 15;
  localparam int GR_DIST = 16;
  localparam int GR_FEED = 17;
  localparam int GR_UNITS = 18;
  localparam int GR_CUTTER = 19;
  localparam int GR_TOOL = 20;
  localparam int GR_COORD = 21;
  localparam int GR_FLOW = 22;
  localparam int GR_SPINDLE = 23;
  localparam int GR_COOLANT = 24;
  localparam int GR_OVERRIDE = 25;
  localparam int NEEDS_PARAMS = 26;

  // pending value slots
  localparam logic [3:0] SLOT_F = 4'd3;
  localparam logic [3:0] SLOT_P = 4'd4;
  localparam logic [3:0] SLOT_S = 4'd5;
  localparam logic [3:0] SLOT_L = 4'd6;
  localparam logic [3:0] SLOT_T = 4'd7;
  localparam logic [3:0] SLOT_N = 4'd8;

  // word letters
  localparam logic [4:0] LET_NONE = 5'd0;
  localparam logic [4:0] LET_F = 5'd6;
  localparam logic [4:0] LET_G = 5'd7;
  localparam logic [4:0] LET_I = 5'd9;
  localparam logic [4:0] LET_J = 5'd10;
  localparam logic [4:0] LET_K = 5'd11;
  localparam logic [4:0] LET_L = 5'd12;
  localparam logic [4:0] LET_M = 5'd13;
  localparam logic [4:0] LET_N = 5'd14;
  localparam logic [4:0] LET_P = 5'd16;
  localparam logic [4:0] LET_R = 5'd18;
  localparam logic [4:0] LET_S = 5'd19;
  localparam logic [4:0] LET_T = 5'd20;
  localparam logic [4:0] LET_X = 5'd24;
  localparam logic [4:0] LET_Y = 5'd25;
  localparam logic [4:0] LET_Z = 5'd26;

  // status codes
  localparam logic [4:0] ST_OK = 5'd0;
  localparam logic [4:0] ST_EMPTY = 5'd1;
  localparam logic [4:0] ST_BAD_G = 5'd2;
  localparam logic [4:0] ST_BAD_M = 5'd3;
  localparam logic [4:0] ST_BAD_LETTER = 5'd4;
  localparam logic [4:0] ST_AXIS_CONFLICT = 5'd5;
  localparam logic [4:0] ST_GROUP_CLASH = 5'd6;
  localparam logic [4:0] ST_S_NEG = 5'd7;
  localparam logic [4:0] ST_F_NEG = 5'd8;
  localparam logic [4:0] ST_N_NEG = 5'd9;
  localparam logic [4:0] ST_N_BIG = 5'd10;
  localparam logic [4:0] ST_T_NEG = 5'd11;
  localparam logic [4:0] ST_T_BIG = 5'd12;
  localparam logic [4:0] ST_G4_NO_P = 5'd13;
  localparam logic [4:0] ST_G4_P_NEG = 5'd14;
  localparam logic [4:0] ST_G10_NO_LP = 5'd15;
  localparam logic [4:0] ST_G10_P_RANGE = 5'd16;
  localparam logic [4:0] ST_G10_BAD_L = 5'd17;
  localparam logic [4:0] ST_G53_MOTION = 5'd18;
  localparam logic [4:0] ST_NO_FEED = 5'd19;
  localparam logic [4:0] ST_G43_MOTION = 5'd20;

  // non-modal actions
  localparam logic [3:0] ACT_NONE = 4'd0;
  localparam logic [3:0] ACT_G4 = 4'd1;
  localparam logic [3:0] ACT_G10 = 4'd2;
  localparam logic [3:0] ACT_G28 = 4'd3;
  localparam logic [3:0] ACT_G28_1 = 4'd4;
  localparam logic [3:0] ACT_G30 = 4'd5;
  localparam logic [3:0] ACT_G30_1 = 4'd6;
  localparam logic [3:0] ACT_G53 = 4'd7;
  localparam logic [3:0] ACT_G92 = 4'd8;
  localparam logic [3:0] ACT_G92_1 = 4'd9;

  localparam logic [2:0] MOT_G0 = 3'd0;
  localparam logic [2:0] MOT_G1 = 3'd1;
  localparam logic [2:0] MOT_G3 = 3'd3;
  localparam logic [2:0] MOT_G80 = 3'd4;

  typedef struct packed {
    logic [1:0] coolant;
    logic [1:0] spindle;
    logic [2:0] flow;
    logic [2:0] coord;
    logic       length_comp;
    logic       units;
    logic       feed_mode;
    logic       distance;
    logic [1:0] plane;
    logic [2:0] motion;
  } modes_t;

  typedef struct packed {
    modes_t     modes;
    logic [3:0] action;
    logic [4:0] status;
  } result_t;

endpackage

/* sv/gcode_line_word_validator.sv */
// Top level of the G-code line word validator: input register, config registers,
// line collector and output register. Depends on gclv_pkg, gclv_line.
//
//   port group   dir   carries
//   s_*          in    one word per transfer, tlast marks the line end
//   m_*          out   one status and modal snapshot per line
//   cfg_*        in    machine position and global offset writes
//
// One word per cycle unless stalled: a word held in the input register is folded
// into the line when it advances, and a line end's result is in m_tdata next cycle.
// The output register decouples the sides; the input stalls only while a line
// end waits on a full, stalled output register. Reset (rst, synchronous) sets
// the held modes to G0 XY G90 G94 G21 G49 G54, running, spindle and coolant off.
module gcode_line_word_validator #(
  parameter int COORD_SYSTEMS = gclv_pkg::COORD_SYSTEMS_DEF,
  parameter int MAX_TOOL      = gclv_pkg::MAX_TOOL_DEF,
  parameter int MAX_LINE      = gclv_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // letter[4:0], integer_part[11:5], has_fraction[12], fraction_digit[16:13],
  // word_value[48:17], zero fill[55:49]
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[4:0], non_modal_action[8:5], motion_mode[11:9], plane[13:12],
  // distance_mode[14], feed_mode[15], units_mode[16], length_comp_mode[17],
  // coord_system[20:18], flow_state[23:21], spindle_mode[25:24],
  // coolant_mode[27:26], zero fill[31:28]
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gclv_pkg::*;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_POS_Z = 3'd2;
  localparam logic [2:0] REG_OFF_X = 3'd3;
  localparam logic [2:0] REG_OFF_Y = 3'd4;
  localparam logic [2:0] REG_OFF_Z = 3'd5;

  logic signed [31:0] machine_pos [AXES];
  logic signed [31:0] base_offset [AXES];

  logic               stage_valid;
  logic [48:0]        stage_data;
  logic               stage_last;
  logic               fire;
  result_t            result;
  result_t            out_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        machine_pos[a] <= '0;
        base_offset[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_X: machine_pos[0] <= cfg_data;
        REG_POS_Y: machine_pos[1] <= cfg_data;
        REG_POS_Z: machine_pos[2] <= cfg_data;
        REG_OFF_X: base_offset[0] <= cfg_data;
        REG_OFF_Y: base_offset[1] <= cfg_data;
        REG_OFF_Z: base_offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a word unless a line end would overrun a stalled result
  assign fire     = stage_valid && (!stage_last || !m_tvalid || m_tready);
  assign s_tready = !stage_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage_data <= s_tdata[48:0];
      stage_last <= s_tlast;
    end
  end

  gclv_line #(
    .COORD_SYSTEMS (COORD_SYSTEMS),
    .MAX_TOOL      (MAX_TOOL),
    .MAX_LINE      (MAX_LINE)
  ) u_line (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .letter         (stage_data[4:0]),
    .integer_part   (stage_data[11:5]),
    .has_fraction   (stage_data[12]),
    .fraction_digit (stage_data[16:13]),
    .word_value     (stage_data[48:17]),
    .end_of_line    (stage_last),
    .machine_pos    (machine_pos),
    .base_offset    (base_offset),
    .result         (result)
  );

  // output register: load on line end, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && stage_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stage_last) out_res <= result;
  end

  assign m_tdata = {4'd0, out_res.modes.coolant, out_res.modes.spindle,
                    out_res.modes.flow, out_res.modes.coord, out_res.modes.length_comp,
                    out_res.modes.units, out_res.modes.feed_mode, out_res.modes.distance,
                    out_res.modes.plane, out_res.modes.motion, out_res.action,
                    out_res.status};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(fire && stage_last))
    else $error("result overwritten while stalled");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !fire |=> stage_valid && $stable(stage_data))
    else $error("stalled word lost");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire && stage_last |=> m_tvalid)
    else $error("line end gave no result");

endmodule

/* sv/gclv_decode.sv */
// Word decoder: maps one G-code word onto mask bits, mode updates and a value slot.
// Depends on gclv_pkg.
module gclv_decode (
  input  logic [4:0]                  letter,
  input  logic [6:0]                  integer_part,
  input  logic                        has_fraction,
  input  logic [3:0]                  fraction_digit,
  input  gclv_pkg::modes_t            modes_in,
  input  logic [3:0]                  action_in,
  output gclv_pkg::modes_t            modes_out,
  output logic [3:0]                  action_out,
  output logic [gclv_pkg::MASK_W-1:0] word,
  output logic [4:0]                  err,
  output logic                        slot_en,
  output logic [3:0]                  slot
);
  import gclv_pkg::*;

  // decode letter, then G or M number
  always_comb begin
    modes_out  = modes_in;
    action_out = action_in;
    word       = '0;
    err        = ST_OK;
    slot_en    = 1'b0;
    slot       = 4'd0;
    unique case (letter)
      LET_X: begin word[B_X] = 1'b1; slot_en = 1'b1; slot = 4'd0; end
      LET_Y: begin word[B_Y] = 1'b1; slot_en = 1'b1; slot = 4'd1; end
      LET_Z: begin word[B_Z] = 1'b1; slot_en = 1'b1; slot = 4'd2; end
      LET_I: word[B_I] = 1'b1;
      LET_J: word[B_J] = 1'b1;
      LET_K: word[B_K] = 1'b1;
      LET_R: word[B_R] = 1'b1;
      LET_F: begin word[B_F] = 1'b1; slot_en = 1'b1; slot = SLOT_F; end
      LET_P: begin word[B_P] = 1'b1; slot_en = 1'b1; slot = SLOT_P; end
      LET_S: begin word[B_S] = 1'b1; slot_en = 1'b1; slot = SLOT_S; end
      LET_L, LET_T, LET_N: begin
        if (has_fraction) begin
          err = ST_BAD_LETTER;
        end else begin
          slot_en = 1'b1;
          if (letter == LET_L) begin word[B_L] = 1'b1; slot = SLOT_L; end
          else if (letter == LET_T) begin word[B_T] = 1'b1; slot = SLOT_T; end
          else begin word[B_N] = 1'b1; slot = SLOT_N; end
        end
      end
      LET_G: begin
        if (has_fraction) begin
          if (fraction_digit == 4'd1 && integer_part == 7'd28) begin
            action_out = ACT_G28_1; word[GR_NONMODAL] = 1'b1;
          end else if (fraction_digit == 4'd1 && integer_part == 7'd30) begin
            action_out = ACT_G30_1; word[GR_NONMODAL] = 1'b1;
          end else if (fraction_digit == 4'd1 && integer_part == 7'd92) begin
            action_out = ACT_G92_1; word[GR_NONMODAL] = 1'b1;
          end else if (fraction_digit == 4'd1 && integer_part == 7'd43) begin
            modes_out.length_comp = 1'b1; word[GR_TOOL] = 1'b1;
          end else begin
            err = ST_BAD_G;
          end
        end else begin
          unique case (integer_part)
            7'd4:  begin action_out = ACT_G4;  word[GR_NONMODAL] = 1'b1;
                         word[NEEDS_PARAMS] = 1'b1; end
            7'd10: begin action_out = ACT_G10; word[GR_NONMODAL] = 1'b1;
                         word[NEEDS_PARAMS] = 1'b1; end
            7'd28: begin action_out = ACT_G28; word[GR_NONMODAL] = 1'b1; end
            7'd30: begin action_out = ACT_G30; word[GR_NONMODAL] = 1'b1; end
            7'd53: begin action_out = ACT_G53; word[GR_NONMODAL] = 1'b1;
                         word[NEEDS_PARAMS] = 1'b1; end
            7'd92: begin action_out = ACT_G92; word[GR_NONMODAL] = 1'b1;
                         word[NEEDS_PARAMS] = 1'b1; end
            7'd0, 7'd1, 7'd2, 7'd3: begin
              modes_out.motion = integer_part[2:0];
              word[GR_MOTION] = 1'b1; word[NEEDS_PARAMS] = 1'b1;
            end
            7'd80: begin modes_out.motion = MOT_G80; word[GR_MOTION] = 1'b1; end
            7'd17, 7'd18, 7'd19: begin
              modes_out.plane = 2'(integer_part - 7'd17); word[GR_PLANE] = 1'b1;
            end
            7'd90, 7'd91: begin
              modes_out.distance = (integer_part == 7'd91);
              word[GR_DIST] = 1'b1;
            end
            7'd93: begin modes_out.feed_mode = 1'b1; word[GR_FEED] = 1'b1; end
            7'd94: begin modes_out.feed_mode = 1'b0; word[GR_FEED] = 1'b1; end
            7'd20: begin modes_out.units = 1'b1; word[GR_UNITS] = 1'b1; end
            7'd21: begin modes_out.units = 1'b0; word[GR_UNITS] = 1'b1; end
            7'd40: word[GR_CUTTER] = 1'b1;
            7'd49: begin modes_out.length_comp = 1'b0; word[GR_TOOL] = 1'b1; end
            7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59: begin
              modes_out.coord = 3'(integer_part - 7'd54); word[GR_COORD] = 1'b1;
            end
            default: err = ST_BAD_G;
          endcase
        end
      end
      LET_M: begin
        if (has_fraction) begin
          err = ST_BAD_LETTER;
        end else begin
          unique case (integer_part)
            7'd0:  begin modes_out.flow = 3'd1; word[GR_FLOW] = 1'b1; end
            7'd1:  begin modes_out.flow = 3'd2; word[GR_FLOW] = 1'b1; end
            7'd2:  begin modes_out.flow = 3'd3; word[GR_FLOW] = 1'b1; end
            7'd30: begin modes_out.flow = 3'd4; word[GR_FLOW] = 1'b1; end
            7'd3:  begin modes_out.spindle = 2'd1; word[GR_SPINDLE] = 1'b1; end
            7'd4:  begin modes_out.spindle = 2'd2; word[GR_SPINDLE] = 1'b1; end
            7'd5:  begin modes_out.spindle = 2'd0; word[GR_SPINDLE] = 1'b1; end
            7'd7:  begin modes_out.coolant = 2'd1; word[GR_COOLANT] = 1'b1; end
            7'd8:  begin modes_out.coolant = 2'd2; word[GR_COOLANT] = 1'b1; end
            7'd9:  begin modes_out.coolant = 2'd0; word[GR_COOLANT] = 1'b1; end
            7'd56: word[GR_OVERRIDE] = 1'b1;
            default: err = ST_BAD_M;
          endcase
        end
      end
      default: err = ST_BAD_LETTER;
    endcase
  end

endmodule

/* sv/gclv_line.sv */
// Line collector: holds the seen-word mask, pending values and modal copies, runs the
// end-of-line checks and commits modal state, feed, offset table and home positions.
// Depends on gclv_pkg and gclv_decode.
module gclv_line #(
  parameter int COORD_SYSTEMS = gclv_pkg::COORD_SYSTEMS_DEF,
  parameter int MAX_TOOL      = gclv_pkg::MAX_TOOL_DEF,
  parameter int MAX_LINE      = gclv_pkg::MAX_LINE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [4:0]              letter,
  input  logic [6:0]              integer_part,
  input  logic                    has_fraction,
  input  logic [3:0]              fraction_digit,
  input  logic signed [31:0]      word_value,
  input  logic                    end_of_line,
  input  logic signed [31:0]      machine_pos [gclv_pkg::AXES],
  input  logic signed [31:0]      base_offset [gclv_pkg::AXES],
  output gclv_pkg::result_t       result
);
  import gclv_pkg::*;

  localparam int RW = (COORD_SYSTEMS > 1) ? $clog2(COORD_SYSTEMS) : 1;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] NEG_ONE = -32'sh0001_0000;
  localparam logic signed [31:0] LINE_LIM = 32'((MAX_LINE + 1) * 65536);
  localparam logic signed [31:0] TOOL_LIM = 32'((MAX_TOOL + 1) * 65536);
  localparam logic signed [31:0] P_LIM = 32'((COORD_SYSTEMS + 1) * 65536);

  modes_t                  held;
  logic signed [31:0]      held_feed;
  logic                    feed_defined;
  modes_t                  line_modes;
  logic [3:0]              line_action;
  logic [MASK_W-1:0]       mask;
  logic signed [31:0]      pend [SLOTS];
  logic [4:0]              line_err;
  logic signed [31:0]      home_pos [2][AXES];
  logic signed [31:0]      coord_tab [COORD_SYSTEMS][AXES];

  modes_t                  d_modes;
  logic [3:0]              d_action;
  logic [MASK_W-1:0]       d_word;
  logic [4:0]              d_err;
  logic                    d_slot_en;
  logic [3:0]              d_slot;

  modes_t                  modes_next;
  logic [3:0]              action_next;
  logic [MASK_W-1:0]       mask_next;
  logic signed [31:0]      pend_next [SLOTS];
  logic [4:0]              err_next;

  modes_t                  fin_modes;
  logic [4:0]              status;
  logic [3:0]              row;
  logic                    l_is_2;
  logic                    l_is_20;
  logic signed [31:0]      l20_val [AXES];
  logic signed [33:0]      l20_diff [AXES];
  logic                    ok;

  gclv_decode u_decode (
    .letter         (letter),
    .integer_part   (integer_part),
    .has_fraction   (has_fraction),
    .fraction_digit (fraction_digit),
    .modes_in       (line_modes),
    .action_in      (line_action),
    .modes_out      (d_modes),
    .action_out     (d_action),
    .word           (d_word),
    .err            (d_err),
    .slot_en        (d_slot_en),
    .slot           (d_slot)
  );

  // fold the current word into the line
  always_comb begin
    modes_next  = line_modes;
    action_next = line_action;
    mask_next   = mask;
    pend_next   = pend;
    err_next    = line_err;
    if (letter != LET_NONE && line_err == ST_OK) begin
      if (d_err != ST_OK) begin
        err_next = d_err;
      end else begin
        modes_next  = d_modes;
        action_next = d_action;
        if (d_slot_en) pend_next[d_slot] = word_value;
        if ((mask & d_word) != '0) begin
          err_next = mask[NEEDS_PARAMS] ? ST_AXIS_CONFLICT : ST_GROUP_CLASH;
        end else begin
          mask_next = mask | d_word;
        end
      end
    end
  end

  // end-of-line checks, first failing check wins
  always_comb begin
    fin_modes = modes_next;
    row       = 4'(pend_next[SLOT_P][19:16] - 4'd1);
    l_is_2    = !pend_next[SLOT_L][31] && pend_next[SLOT_L][30:16] == 15'd2;
    l_is_20   = !pend_next[SLOT_L][31] && pend_next[SLOT_L][30:16] == 15'd20;
    if (pend_next[SLOT_P] > NEG_ONE && pend_next[SLOT_P] < ONE) begin
      row = {1'b0, held.coord};
    end
    priority if (err_next != ST_OK) status = err_next;
    else if (mask_next == '0) status = ST_EMPTY;
    else if (mask_next[B_S] && pend_next[SLOT_S] < 0) status = ST_S_NEG;
    else if (mask_next[B_F] && pend_next[SLOT_F] < 0) status = ST_F_NEG;
    else if (mask_next[B_N] && pend_next[SLOT_N] <= NEG_ONE) status = ST_N_NEG;
    else if (mask_next[B_N] && pend_next[SLOT_N] >= LINE_LIM) status = ST_N_BIG;
    else if (mask_next[B_T] && pend_next[SLOT_T] <= NEG_ONE) status = ST_T_NEG;
    else if (mask_next[B_T] && pend_next[SLOT_T] >= TOOL_LIM) status = ST_T_BIG;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G4 && !mask_next[B_P])
      status = ST_G4_NO_P;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G4 && pend_next[SLOT_P] < 0)
      status = ST_G4_P_NEG;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G10 &&
             (!mask_next[B_L] || !mask_next[B_P]))
      status = ST_G10_NO_LP;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G10 &&
             (pend_next[SLOT_P] <= NEG_ONE || pend_next[SLOT_P] >= P_LIM))
      status = ST_G10_P_RANGE;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G10 && !l_is_2 && !l_is_20)
      status = ST_G10_BAD_L;
    else if (mask_next[GR_NONMODAL] && action_next == ACT_G53 &&
             modes_next.motion != MOT_G0 && modes_next.motion != MOT_G1)
      status = ST_G53_MOTION;
    else if (modes_next.feed_mode && modes_next.motion >= MOT_G1 &&
             modes_next.motion <= MOT_G3 && !mask_next[B_F] && !feed_defined)
      status = ST_NO_FEED;
    else if (mask_next[GR_TOOL] && mask_next[GR_MOTION] && modes_next.length_comp)
      status = ST_G43_MOTION;
    else status = ST_OK;
    // P0 on G10 takes the held work system
    if (action_next == ACT_G10 && pend_next[SLOT_P] > NEG_ONE && pend_next[SLOT_P] < ONE)
      fin_modes.coord = held.coord;
  end

  // L20 value: position minus global offset minus word, saturated
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      l20_diff[a] = 34'(machine_pos[a]) - 34'(base_offset[a]) - 34'(pend_next[a]);
      if (l20_diff[a] > 34'sh0_7FFF_FFFF) l20_val[a] = 32'sh7FFF_FFFF;
      else if (l20_diff[a] < -34'sh0_8000_0000) l20_val[a] = 32'sh8000_0000;
      else l20_val[a] = l20_diff[a][31:0];
    end
  end

  assign ok = (status == ST_OK);

  always_comb begin
    result.status = status;
    result.action = ok ? action_next : ACT_NONE;
    result.modes  = ok ? fin_modes : held;
  end

  // line and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      held_feed    <= '0;
      feed_defined <= 1'b0;
      line_modes   <= '0;
      line_action  <= ACT_NONE;
      mask         <= '0;
      line_err     <= ST_OK;
    end else if (fire) begin
      if (end_of_line) begin
        if (ok) begin
          held <= fin_modes;
          if (mask_next[B_F]) begin
            held_feed    <= pend_next[SLOT_F];
            feed_defined <= 1'b1;
          end
        end
        line_modes  <= ok ? fin_modes : held;
        line_action <= ACT_NONE;
        mask        <= '0;
        line_err    <= ST_OK;
      end else begin
        line_modes  <= modes_next;
        line_action <= action_next;
        mask        <= mask_next;
        line_err    <= err_next;
      end
    end
  end

  // pending values: clear at line end, capture words otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) pend[s] <= '0;
    end else if (fire) begin
      for (int s = 0; s < SLOTS; s++) pend[s] <= end_of_line ? '0 : pend_next[s];
    end
  end

  // offset table and home captures on a passing line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < COORD_SYSTEMS; r++)
        for (int a = 0; a < AXES; a++) coord_tab[r][a] <= '0;
      for (int h = 0; h < 2; h++)
        for (int a = 0; a < AXES; a++) home_pos[h][a] <= '0;
    end else if (fire && end_of_line && ok) begin
      if (action_next == ACT_G10 && int'(row) < COORD_SYSTEMS) begin
        for (int a = 0; a < AXES; a++)
          if (mask_next[a]) coord_tab[row[RW-1:0]][a] <= l_is_2 ? pend_next[a] : l20_val[a];
      end
      if (action_next == ACT_G28_1)
        for (int a = 0; a < AXES; a++) home_pos[0][a] <= machine_pos[a];
      if (action_next == ACT_G30_1)
        for (int a = 0; a < AXES; a++) home_pos[1][a] <= machine_pos[a];
    end
  end

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_line |=> mask == '0 && line_err == ST_OK)
    else $error("line state not cleared after line end");
  a_err_no_action: assert property (@(posedge clk) disable iff (rst)
    result.status != ST_OK |-> result.action == ACT_NONE)
    else $error("action reported on failing line");
  a_feed_sticky: assert property (@(posedge clk) disable iff (rst)
    feed_defined |=> feed_defined)
    else $error("feed_defined dropped");
  a_held_only_on_eol: assert property (@(posedge clk) disable iff (rst)
    !(fire && end_of_line) |=> $stable(held))
    else $error("held modes changed outside line end");

endmodule

/* test/gclv_checker.sv */
// Line checker for the G-code line word validator: watches the word and result
// streams, predicts each line's status and modal snapshot, and counts mismatches.
// Depends on gclv_pkg.
module gclv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          mismatches,
  output int          lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gclv_pkg::*;

  localparam int NUM_COORD = COORD_SYSTEMS_DEF;
  localparam int TOP_TOOL  = MAX_TOOL_DEF;
  localparam int TOP_LINE  = MAX_LINE_DEF;

  modes_t        held_modes;
  modes_t        line_modes;
  logic [3:0]    line_act;
  logic [26:0]   seen;
  longint        pend [SLOTS];
  logic [4:0]    line_err;
  bit            feed_known;
  result_t       line_results [$];

  // truncate a Q16.16 value toward zero
  function automatic longint whole_part(longint q);
    return (q >= 0) ? (q >>> 16) : -((-q) >>> 16);
  endfunction

  function automatic void clear_line();
    line_modes = held_modes;
    line_act   = ACT_NONE;
    seen       = '0;
    line_err   = ST_OK;
    foreach (pend[i]) pend[i] = 0;
  endfunction

  // fold one word into the line being collected
  function automatic void fold_word(logic [4:0] ltr, logic [6:0] ip, logic fr,
                                    logic [3:0] fd, longint val);
    logic [26:0] bits;
    int          slot;
    logic [4:0]  err;
    bits = '0;
    slot = -1;
    err  = ST_OK;
    case (ltr)
      LET_X: begin bits[B_X] = 1; slot = 0; end
      LET_Y: begin bits[B_Y] = 1; slot = 1; end
      LET_Z: begin bits[B_Z] = 1; slot = 2; end
      LET_I: bits[B_I] = 1;
      LET_J: bits[B_J] = 1;
      LET_K: bits[B_K] = 1;
      LET_R: bits[B_R] = 1;
      LET_F: begin bits[B_F] = 1; slot = SLOT_F; end
      LET_P: begin bits[B_P] = 1; slot = SLOT_P; end
      LET_S: begin bits[B_S] = 1; slot = SLOT_S; end
      LET_L: if (!fr) begin bits[B_L] = 1; slot = SLOT_L; end else err = ST_BAD_LETTER;
      LET_T: if (!fr) begin bits[B_T] = 1; slot = SLOT_T; end else err = ST_BAD_LETTER;
      LET_N: if (!fr) begin bits[B_N] = 1; slot = SLOT_N; end else err = ST_BAD_LETTER;
      LET_G: begin
        if (fr) begin
          err = ST_BAD_G;
          if (fd == 4'd1) begin
            err = ST_OK;
            case (ip)
              7'd28: begin line_act = ACT_G28_1; bits[GR_NONMODAL] = 1; end
              7'd30: begin line_act = ACT_G30_1; bits[GR_NONMODAL] = 1; end
              7'd92: begin line_act = ACT_G92_1; bits[GR_NONMODAL] = 1; end
              7'd43: begin line_modes.length_comp = 1; bits[GR_TOOL] = 1; end
              default: err = ST_BAD_G;
            endcase
          end
        end else begin
          case (ip)
            7'd4:  begin line_act = ACT_G4;  bits[GR_NONMODAL] = 1; bits[NEEDS_PARAMS] = 1; end
            7'd10: begin line_act = ACT_G10; bits[GR_NONMODAL] = 1; bits[NEEDS_PARAMS] = 1; end
            7'd28: begin line_act = ACT_G28; bits[GR_NONMODAL] = 1; end
            7'd30: begin line_act = ACT_G30; bits[GR_NONMODAL] = 1; end
            7'd53: begin line_act = ACT_G53; bits[GR_NONMODAL] = 1; bits[NEEDS_PARAMS] = 1; end
            7'd92: begin line_act = ACT_G92; bits[GR_NONMODAL] = 1; bits[NEEDS_PARAMS] = 1; end
            7'd0, 7'd1, 7'd2, 7'd3: begin
              line_modes.motion = ip[2:0];
              bits[GR_MOTION] = 1;
              bits[NEEDS_PARAMS] = 1;
            end
            7'd80: begin line_modes.motion = MOT_G80; bits[GR_MOTION] = 1; end
            7'd17, 7'd18, 7'd19: begin
              line_modes.plane = 2'(ip - 7'd17);
              bits[GR_PLANE] = 1;
            end
            7'd90, 7'd91: begin line_modes.distance = ip[0]; bits[GR_DIST] = 1; end
            7'd93: begin line_modes.feed_mode = 1; bits[GR_FEED] = 1; end
            7'd94: begin line_modes.feed_mode = 0; bits[GR_FEED] = 1; end
            7'd20: begin line_modes.units = 1; bits[GR_UNITS] = 1; end
            7'd21: begin line_modes.units = 0; bits[GR_UNITS] = 1; end
            7'd40: bits[GR_CUTTER] = 1;
            7'd49: begin line_modes.length_comp = 0; bits[GR_TOOL] = 1; end
            7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59: begin
              line_modes.coord = 3'(ip - 7'd54);
              bits[GR_COORD] = 1;
            end
            default: err = ST_BAD_G;
          endcase
        end
      end
      LET_M: begin
        if (fr) err = ST_BAD_LETTER;
        else begin
          case (ip)
            7'd0:  begin line_modes.flow = 3'd1; bits[GR_FLOW] = 1; end
            7'd1:  begin line_modes.flow = 3'd2; bits[GR_FLOW] = 1; end
            7'd2:  begin line_modes.flow = 3'd3; bits[GR_FLOW] = 1; end
            7'd30: begin line_modes.flow = 3'd4; bits[GR_FLOW] = 1; end
            7'd3:  begin line_modes.spindle = 2'd1; bits[GR_SPINDLE] = 1; end
            7'd4:  begin line_modes.spindle = 2'd2; bits[GR_SPINDLE] = 1; end
            7'd5:  begin line_modes.spindle = 2'd0; bits[GR_SPINDLE] = 1; end
            7'd7:  begin line_modes.coolant = 2'd1; bits[GR_COOLANT] = 1; end
            7'd8:  begin line_modes.coolant = 2'd2; bits[GR_COOLANT] = 1; end
            7'd9:  begin line_modes.coolant = 2'd0; bits[GR_COOLANT] = 1; end
            7'd56: bits[GR_OVERRIDE] = 1;
            default: err = ST_BAD_M;
          endcase
        end
      end
      default: err = ST_BAD_LETTER;
    endcase
    if (err != ST_OK) begin
      line_err = err;
      return;
    end
    if (slot >= 0) pend[slot] = val;
    if ((seen & bits) != '0) line_err = seen[NEEDS_PARAMS] ? ST_AXIS_CONFLICT : ST_GROUP_CLASH;
    else seen |= bits;
  endfunction

  // line end checks; commit modes and feed on success
  function automatic logic [4:0] judge_line();
    longint n;
    longint p;
    if (line_err != ST_OK) return line_err;
    if (seen == '0) return ST_EMPTY;
    if (seen[B_S] && pend[SLOT_S] < 0) return ST_S_NEG;
    if (seen[B_F] && pend[SLOT_F] < 0) return ST_F_NEG;
    if (seen[B_N]) begin
      n = whole_part(pend[SLOT_N]);
      if (n < 0) return ST_N_NEG;
      if (n > TOP_LINE) return ST_N_BIG;
    end
    if (seen[B_T]) begin
      n = whole_part(pend[SLOT_T]);
      if (n < 0) return ST_T_NEG;
      if (n > TOP_TOOL) return ST_T_BIG;
    end
    if (seen[GR_NONMODAL]) begin
      if (line_act == ACT_G4) begin
        if (!seen[B_P]) return ST_G4_NO_P;
        if (pend[SLOT_P] < 0) return ST_G4_P_NEG;
      end else if (line_act == ACT_G10) begin
        if (!seen[B_L] || !seen[B_P]) return ST_G10_NO_LP;
        p = whole_part(pend[SLOT_P]);
        if (p < 0 || p > NUM_COORD) return ST_G10_P_RANGE;
        if (p == 0) line_modes.coord = held_modes.coord;
        n = whole_part(pend[SLOT_L]);
        if (n != 2 && n != 20) return ST_G10_BAD_L;
      end else if (line_act == ACT_G53) begin
        if (line_modes.motion != MOT_G0 && line_modes.motion != MOT_G1) return ST_G53_MOTION;
      end
    end
    if (line_modes.feed_mode && line_modes.motion >= MOT_G1 && line_modes.motion <= MOT_G3
        && !seen[B_F] && !feed_known) return ST_NO_FEED;
    if (seen[GR_TOOL] && seen[GR_MOTION] && line_modes.length_comp) return ST_G43_MOTION;
    held_modes = line_modes;
    if (seen[B_F]) feed_known = 1;
    return ST_OK;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic [4:0] st;
    int    wf [12];
    int    gf [12];
    string fname [12];
    if (rst) begin
      held_modes = '0;
      feed_known = 0;
      line_results.delete();
      mismatches = 0;
      clear_line();
    end else begin
      // compare a result transfer with the oldest predicted line
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[27:0]);
        if (line_results.size() == 0) begin
          note_mismatch("unexpected result, status", -1, got.status);
        end else begin
          want = line_results.pop_front();
          fname = '{"status", "non_modal_action", "motion_mode", "plane", "distance_mode",
                    "feed_mode", "units_mode", "length_comp_mode", "coord_system",
                    "flow_state", "spindle_mode", "coolant_mode"};
          wf = '{want.status, want.action, want.modes.motion, want.modes.plane,
                 want.modes.distance, want.modes.feed_mode, want.modes.units,
                 want.modes.length_comp, want.modes.coord, want.modes.flow,
                 want.modes.spindle, want.modes.coolant};
          gf = '{got.status, got.action, got.modes.motion, got.modes.plane,
                 got.modes.distance, got.modes.feed_mode, got.modes.units,
                 got.modes.length_comp, got.modes.coord, got.modes.flow,
                 got.modes.spindle, got.modes.coolant};
          foreach (wf[i]) if (wf[i] != gf[i]) note_mismatch(fname[i], wf[i], gf[i]);
        end
      end
      // fold a word transfer; a line end predicts one result
      if (s_tvalid && s_tready) begin
        if (s_tdata[4:0] != LET_NONE && line_err == ST_OK)
          fold_word(s_tdata[4:0], s_tdata[11:5], s_tdata[12], s_tdata[16:13],
                    longint'($signed(s_tdata[48:17])));
        if (s_tlast) begin
          st = judge_line();
          want.status = st;
          want.action = (st == ST_OK) ? line_act : ACT_NONE;
          want.modes  = held_modes;
          line_results.push_back(want);
          clear_line();
        end
      end
    end
    lines_pending = line_results.size();
  end

endmodule

/* test/tb_gcode_line_word_validator.sv */
// Testbench top for the G-code line word validator: clock, reset, word and
// register stimulus, output back-pressure and verdict. Depends on gclv_pkg,
// gclv_checker and gcode_line_word_validator.
module tb_gcode_line_word_validator;
  timeunit 1ns;
  timeprecision 1ps;
  import gclv_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 1;
  logic [31:0] m_tdata;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int mismatches;
  int lines_pending;
  int words_sent = 0;
  int quiet_cycles = 0;
  bit calm = 0;

  gcode_line_word_validator u_dut (.*);

  gclv_checker u_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles <= 0;
    else if (!rst) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 1500) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // one word transfer; called and returning at a falling edge
  task automatic send_word(logic [4:0] ltr, logic [6:0] ip, logic fr, logic [3:0] fd,
                           logic [31:0] val, logic eol);
    while (!calm && $urandom_range(99) < 21) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {7'd0, val, fd, fr, ip, ltr};
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic g_word(logic [6:0] ip, logic eol);
    send_word(LET_G, ip, 0, 4'd0, '0, eol);
  endtask

  task automatic g_dot1(logic [6:0] ip, logic eol);
    send_word(LET_G, ip, 1, 4'd1, 32'h0000_1999, eol);
  endtask

  task automatic v_word(logic [4:0] ltr, int whole, logic eol);
    send_word(ltr, 7'd0, 0, 4'd0, 32'(whole) << 16, eol);
  endtask

  // write every register once, quiet block assumed
  task automatic load_regs(int flavor);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1;
      cfg_index <= 3'(i);
      case (flavor)
        0: cfg_data <= 32'h0000_0000;
        1: cfg_data <= 32'h7fff_ffff;
        2: cfg_data <= 32'h8000_0000;
        default: cfg_data <= $urandom;
      endcase
      @(negedge clk);
    end
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // stop offering words and wait for every predicted line to come out
  task automatic drain();
    s_tvalid <= 0;
    while (lines_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Q16.16 value: mostly modest, sometimes negative, sometimes anything
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom;
    if (r < 25) return 32'(-$urandom_range(1, 400000));
    if (r < 40) return 32'($urandom_range(0, 140)) << 16;
    return 32'($urandom_range(0, 9000000));
  endfunction

  // one word, mostly well formed
  task automatic random_word(logic eol);
    logic [6:0] g_codes [26] = '{0, 1, 2, 3, 4, 10, 17, 18, 19, 20, 21, 28, 30, 40, 43,
                                 49, 53, 54, 55, 56, 57, 58, 59, 80, 90, 93};
    logic [6:0] m_codes [11] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 30, 56};
    logic [4:0] params [13] = '{LET_X, LET_Y, LET_Z, LET_I, LET_J, LET_K, LET_R, LET_F,
                                LET_P, LET_S, LET_L, LET_T, LET_N};
    int kind;
    kind = $urandom_range(99);
    if (kind < 30)
      g_word(g_codes[$urandom_range(25)], eol);
    else if (kind < 35)
      g_word(7'($urandom_range(91, 94)), eol);
    else if (kind < 40)
      g_dot1($urandom_range(1) ? 7'd28 : ($urandom_range(1) ? 7'd43 : 7'd92), eol);
    else if (kind < 50)
      send_word(LET_M, m_codes[$urandom_range(10)], 0, 4'd0, '0, eol);
    else if (kind < 85)
      send_word(params[$urandom_range(12)], 7'($urandom), 0, 4'($urandom), pick_value(),
                eol);
    else if (kind < 90)
      send_word(LET_NONE, 7'($urandom), 1'($urandom), 4'($urandom), $urandom, eol);
    else
      send_word(5'($urandom), 7'($urandom), 1'($urandom), 4'($urandom), $urandom, eol);
  endtask

  // one line: mostly command lines of known shape with random content
  task automatic random_line();
    int shape;
    int n;
    shape = $urandom_range(99);
    if (shape < 20) begin
      g_word(10, 0);
      v_word(LET_L, $urandom_range(3) == 0 ? $urandom_range(0, 25)
                                           : ($urandom_range(1) ? 2 : 20), 0);
      v_word(LET_P, $urandom_range(0, 7), 0);
      if ($urandom_range(1)) v_word(LET_X, $urandom_range(0, 50), 0);
      v_word(LET_Z, $urandom_range(0, 50) - 25, 1);
    end else if (shape < 45) begin
      if ($urandom_range(1)) g_word($urandom_range(1) ? 7'd93 : 7'd94, 0);
      g_word(7'($urandom_range(0, 3)), 0);
      send_word(LET_X, 7'd0, 0, 4'd0, pick_value(), 0);
      if ($urandom_range(1)) send_word(LET_F, 7'd0, 0, 4'd0, pick_value(), 0);
      random_word(1);
    end else if (shape < 55) begin
      g_word($urandom_range(1) ? 7'd4 : 7'd53, 0);
      random_word(0);
      random_word(1);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 1; i < n; i++) random_word(0);
      random_word(1);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    load_regs(3);

    // directed lines: an empty line, a selection of special actions and line end checks
    send_word(LET_NONE, 7'd0, 0, 4'd0, '0, 1);
    g_word(93, 0); g_word(1, 1);
    g_word(94, 0); g_word(1, 0); v_word(LET_F, 100, 1);
    g_dot1(28, 1);
    g_dot1(30, 1);
    g_dot1(92, 1);
    g_dot1(43, 0); g_word(1, 1);
    g_word(10, 0); v_word(LET_L, 2, 0); v_word(LET_P, 1, 0); v_word(LET_X, -3, 1);
    g_word(10, 0); v_word(LET_L, 20, 0); v_word(LET_P, 0, 1);
    g_word(10, 0); v_word(LET_P, 7, 0); v_word(LET_L, 2, 1);
    g_word(4, 1);
    g_word(53, 0); g_word(2, 1);
    v_word(LET_T, 128, 1);
    g_word(0, 0); g_word(1, 1);
    send_word(LET_M, 7'd6, 0, 4'd0, '0, 1);
    send_word(5'd31, 7'd127, 1, 4'd15, 32'hffff_ffff, 1);
    g_word(20, 1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      load_regs(phase == 0 ? 1 : (phase == 1 ? 2 : (phase == 2 ? 0 : 3)));
      while (words_sent < 30 + 350 * (phase + 1)) begin
        calm = (phase == 1 && words_sent > 500 && words_sent < 650);
        random_line();
      end
      calm = 0;
      s_tvalid <= 0;
      drain();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && lines_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
